// ===== sv/lcl_pkg.sv =====
// Shared types and constants of the LFU cache with LRU tie-break.
package lcl_pkg;

    // Field widths fixed by the item format.
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int USES_W = 32;
    localparam int CAP_W  = 7;

    // Configuration port geometry: one 32-bit register per word.
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    // Operation codes carried in the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Use counts saturate at this value.
    localparam logic [USES_W-1:0] USES_MAX = '1;

    typedef struct packed {
        logic                     mode;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [DATA_W-1:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_data;
    } rsp_item_t;

    // One word of the entry store.
    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
        logic [USES_W-1:0]        uses;
    } entry_t;

    // Sequencer to scan unit.
    typedef struct packed {
        logic start;
        logic sample;
    } scan_ctrl_t;

    // Scan unit to sequencer.
    typedef struct packed {
        logic hit;
        logic free_found;
        logic victim_found;
    } scan_stat_t;

endpackage

// ===== sv/lfu_cache_lru_tiebreak_unit.sv =====
// Top level of the LFU key-value cache with LRU tie-break: sequencer, stores and config port.
//
// This block is a key-value cache of ENTRIES slots that replaces the least frequently
// used entry, picking the least recently accessed one among entries of equal use count.
// Each request item is a get or a put of a 32-bit key, and each gives exactly one
// response item: hit tells whether the key was present, and read_data holds the stored
// value on a get hit and zero otherwise. One compare unit walks the entry store one
// slot per cycle, checking the key, the first free slot and the eviction candidate.
// The walk is lengthened by the store's registered read, and a final commit state
// writes the update. The block then returns to idle and only there accepts a new item.
// The request side is stalled outside idle; a finished result waits in an output
// register and the next request is taken meanwhile. If the previous result is
// still waiting when the next commit is due, the commit state is held until the
// receiver takes it, which lengthens the item by the receiver's stall. Recency ranks
// are updated lazily: the adjustment an item makes to the other entries is applied
// while the next item's scan passes over them. After reset the block first clears the
// valid flags of the entry store, one slot per cycle, and accepts no request until
// that is done. The capacity register (reset 64, values above ENTRIES act as ENTRIES,
// zero makes puts change nothing) is written over the APB-style port.
module lfu_cache_lru_tiebreak_unit #(
    parameter int ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  lcl_pkg::req_item_t             req_item,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output lcl_pkg::rsp_item_t             rsp_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcl_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = IW + 1;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = OW + lcl_pkg::CAP_W;
    localparam int EW   = $bits(lcl_pkg::entry_t);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic sample_vld_reg, sample_vld_next;
    logic [IW-1:0] sample_idx_reg, sample_idx_next;
    lcl_pkg::req_item_t item_reg, item_next;
    logic [OW-1:0] occupancy_reg, occupancy_next;
    logic pend_vld_reg, pend_vld_next;
    logic [IW-1:0] pend_slot_reg, pend_slot_next;
    logic [IW:0] pend_old_reg, pend_old_next;
    logic rsp_valid_reg, rsp_valid_next;
    lcl_pkg::rsp_item_t rsp_item_reg, rsp_item_next;
    logic [lcl_pkg::CAP_W-1:0] capacity_reg;

    // Store ports.
    logic            entry_we;
    logic [IW-1:0]   entry_waddr;
    logic [EW-1:0]   entry_wdata;
    logic [IW-1:0]   rd_addr;
    logic [EW-1:0]   entry_rdata;
    logic            rank_we;
    logic [IW-1:0]   rank_waddr;
    logic [IW-1:0]   rank_wdata;
    logic [IW-1:0]   rank_rdata;

    // Scan unit interface.
    lcl_pkg::scan_ctrl_t               scan_ctrl;
    lcl_pkg::scan_stat_t               scan_stat;
    lcl_pkg::entry_t                   sample_entry;
    logic [IW-1:0]                     scan_rank_out;
    logic                              scan_rank_we;
    logic [IW-1:0]                     found_idx;
    logic [IW-1:0]                     found_rank;
    logic signed [lcl_pkg::DATA_W-1:0] found_data;
    logic [lcl_pkg::USES_W-1:0]        found_uses;
    logic [IW-1:0]                     free_idx;
    logic [IW-1:0]                     victim_idx;
    logic [IW-1:0]                     victim_rank;

    // Commit decision.
    logic                cap_zero;
    logic [CMPW-1:0]     cap_eff;
    logic                occ_below;
    logic                is_put;
    logic                do_write;
    logic                take_free;
    logic                proceed;
    logic [IW-1:0]       commit_slot;
    lcl_pkg::entry_t     commit_entry;
    logic                cfg_write;

    assign sample_entry = lcl_pkg::entry_t'(entry_rdata);

    lcl_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (entry_waddr),
        .wdata (entry_wdata),
        .raddr (rd_addr),
        .rdata (entry_rdata)
    );

    lcl_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rd_addr),
        .rdata (rank_rdata)
    );

    lcl_scan_unit #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (scan_ctrl),
        .sample_idx  (sample_idx_reg),
        .entry       (sample_entry),
        .rank_in     (rank_rdata),
        .key         (item_reg.lookup_key),
        .pend_vld    (pend_vld_reg),
        .pend_slot   (pend_slot_reg),
        .pend_old    (pend_old_reg),
        .rank_out    (scan_rank_out),
        .rank_we     (scan_rank_we),
        .stat        (scan_stat),
        .found_idx   (found_idx),
        .found_rank  (found_rank),
        .found_data  (found_data),
        .found_uses  (found_uses),
        .free_idx    (free_idx),
        .victim_idx  (victim_idx),
        .victim_rank (victim_rank)
    );

    // Effective capacity is the register clipped to the number of slots.
    always_comb
    begin
        cap_zero  = (capacity_reg == '0);
        cap_eff   = (CMPW'(capacity_reg) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES)
                                                           : CMPW'(capacity_reg);
        occ_below = CMPW'(occupancy_reg) < cap_eff;
    end

    // What the item does once the scan is complete.
    always_comb
    begin
        is_put    = (item_reg.mode == lcl_pkg::MODE_PUT);
        do_write  = is_put ? !cap_zero : scan_stat.hit;
        take_free = is_put && !cap_zero && !scan_stat.hit && occ_below;
        proceed   = !rsp_valid_reg || !rsp_stall;

        if (scan_stat.hit)
        begin
            commit_slot = found_idx;
        end
        else if (occ_below)
        begin
            commit_slot = free_idx;
        end
        else
        begin
            commit_slot = victim_idx;
        end

        commit_entry.valid = 1'b1;
        commit_entry.key   = item_reg.lookup_key;
        commit_entry.data  = is_put ? item_reg.write_data : found_data;
        if (!scan_stat.hit)
        begin
            commit_entry.uses = lcl_pkg::USES_W'(1);
        end
        else if (found_uses == lcl_pkg::USES_MAX)
        begin
            commit_entry.uses = found_uses;
        end
        else
        begin
            commit_entry.uses = found_uses + lcl_pkg::USES_W'(1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sample_vld_next = 1'b0;
        sample_idx_next = sample_idx_reg;
        item_next       = item_reg;
        occupancy_next  = occupancy_reg;
        pend_vld_next   = pend_vld_reg;
        pend_slot_next  = pend_slot_reg;
        pend_old_next   = pend_old_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_item_next   = rsp_item_reg;

        scan_ctrl.start  = 1'b0;
        scan_ctrl.sample = sample_vld_reg;

        entry_we    = 1'b0;
        entry_waddr = commit_slot;
        entry_wdata = EW'(commit_entry);
        rank_we     = scan_rank_we;
        rank_waddr  = sample_idx_reg;
        rank_wdata  = scan_rank_out;
        rd_addr     = (cnt_reg < CW'(ENTRIES)) ? cnt_reg[IW-1:0] : '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Only the valid flag matters; the whole word is zeroed.
                entry_we    = 1'b1;
                entry_waddr = cnt_reg[IW-1:0];
                entry_wdata = '0;
                if (cnt_reg == CW'(ENTRIES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next       = req_item;
                    scan_ctrl.start = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Read data lines up with the sample flag in the cycle after the address.
                if (cnt_reg < CW'(ENTRIES))
                begin
                    sample_vld_next = 1'b1;
                    sample_idx_next = cnt_reg[IW-1:0];
                    cnt_next        = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                rank_we    = 1'b0;
                rank_waddr = commit_slot;
                rank_wdata = '0;
                if (proceed)
                begin
                    entry_we = do_write;
                    rank_we  = do_write;

                    // Hit, eviction and free-slot fill all age the entries that were
                    // more recent than a threshold; a fill ages every entry.
                    pend_vld_next  = do_write;
                    pend_slot_next = commit_slot;
                    if (scan_stat.hit)
                    begin
                        pend_old_next = {1'b0, found_rank};
                    end
                    else if (occ_below)
                    begin
                        pend_old_next = CW'(ENTRIES);
                    end
                    else
                    begin
                        pend_old_next = {1'b0, victim_rank};
                    end

                    if (take_free)
                    begin
                        occupancy_next = occupancy_reg + OW'(1);
                    end

                    rsp_valid_next          = 1'b1;
                    rsp_item_next.hit       = scan_stat.hit;
                    rsp_item_next.read_data = (!is_put && scan_stat.hit) ? found_data : '0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            sample_vld_reg <= 1'b0;
            occupancy_reg  <= '0;
            pend_vld_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sample_vld_reg <= sample_vld_next;
            occupancy_reg  <= occupancy_next;
            pend_vld_reg   <= pend_vld_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_idx_reg <= sample_idx_next;
        item_reg       <= item_next;
        pend_slot_reg  <= pend_slot_next;
        pend_old_reg   <= pend_old_next;
        rsp_item_reg   <= rsp_item_next;
    end

    // Configuration register.
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[lcl_pkg::ADDR_W-1:2] == lcl_pkg::REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lcl_pkg::CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[lcl_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[lcl_pkg::ADDR_W-1:2] == lcl_pkg::REG_CAPACITY)
                    ? 32'(capacity_reg) : 32'd0;
    assign pready = 1'b1;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ===== sv/lcl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lcl_scan_unit.sv =====
// Per-entry compare unit that accumulates the key match, free slot and victim over a scan.
module lcl_scan_unit #(
    parameter int ENTRIES = 64,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcl_pkg::scan_ctrl_t               ctrl,
    input  logic [IW-1:0]                     sample_idx,
    input  lcl_pkg::entry_t                   entry,
    input  logic [IW-1:0]                     rank_in,
    input  logic signed [lcl_pkg::KEY_W-1:0]  key,
    input  logic                              pend_vld,
    input  logic [IW-1:0]                     pend_slot,
    input  logic [IW:0]                       pend_old,
    output logic [IW-1:0]                     rank_out,
    output logic                              rank_we,
    output lcl_pkg::scan_stat_t               stat,
    output logic [IW-1:0]                     found_idx,
    output logic [IW-1:0]                     found_rank,
    output logic signed [lcl_pkg::DATA_W-1:0] found_data,
    output logic [lcl_pkg::USES_W-1:0]        found_uses,
    output logic [IW-1:0]                     free_idx,
    output logic [IW-1:0]                     victim_idx,
    output logic [IW-1:0]                     victim_rank
);

    logic hit_reg, hit_next;
    logic free_found_reg, free_found_next;
    logic victim_found_reg, victim_found_next;
    logic [IW-1:0] found_idx_reg, found_idx_next;
    logic [IW-1:0] found_rank_reg, found_rank_next;
    logic signed [lcl_pkg::DATA_W-1:0] found_data_reg, found_data_next;
    logic [lcl_pkg::USES_W-1:0] found_uses_reg, found_uses_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] victim_idx_reg, victim_idx_next;
    logic [IW-1:0] victim_rank_reg, victim_rank_next;
    logic [lcl_pkg::USES_W-1:0] victim_uses_reg, victim_uses_next;

    logic          adjust;
    logic [IW-1:0] rank_adj;
    logic          match;
    logic          better;

    always_comb
    begin
        // The previous item's deferred recency update is applied as each entry passes.
        adjust   = entry.valid && pend_vld && (sample_idx != pend_slot) &&
                   ({1'b0, rank_in} < pend_old);
        rank_adj = adjust ? rank_in + IW'(1) : rank_in;
        match    = entry.valid && (entry.key == key);
        better   = !victim_found_reg || (entry.uses < victim_uses_reg) ||
                   ((entry.uses == victim_uses_reg) && (rank_adj > victim_rank_reg));

        hit_next          = hit_reg;
        free_found_next   = free_found_reg;
        victim_found_next = victim_found_reg;
        found_idx_next    = found_idx_reg;
        found_rank_next   = found_rank_reg;
        found_data_next   = found_data_reg;
        found_uses_next   = found_uses_reg;
        free_idx_next     = free_idx_reg;
        victim_idx_next   = victim_idx_reg;
        victim_rank_next  = victim_rank_reg;
        victim_uses_next  = victim_uses_reg;

        if (ctrl.start)
        begin
            hit_next          = 1'b0;
            free_found_next   = 1'b0;
            victim_found_next = 1'b0;
        end
        else if (ctrl.sample)
        begin
            if (match && !hit_reg)
            begin
                hit_next        = 1'b1;
                found_idx_next  = sample_idx;
                found_rank_next = rank_adj;
                found_data_next = entry.data;
                found_uses_next = entry.uses;
            end
            if (!entry.valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = sample_idx;
            end
            if (entry.valid && better)
            begin
                victim_found_next = 1'b1;
                victim_idx_next   = sample_idx;
                victim_rank_next  = rank_adj;
                victim_uses_next  = entry.uses;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
        end
        else
        begin
            hit_reg          <= hit_next;
            free_found_reg   <= free_found_next;
            victim_found_reg <= victim_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg   <= found_idx_next;
        found_rank_reg  <= found_rank_next;
        found_data_reg  <= found_data_next;
        found_uses_reg  <= found_uses_next;
        free_idx_reg    <= free_idx_next;
        victim_idx_reg  <= victim_idx_next;
        victim_rank_reg <= victim_rank_next;
        victim_uses_reg <= victim_uses_next;
    end

    assign rank_out          = rank_adj;
    assign rank_we           = ctrl.sample && entry.valid;
    assign stat.hit          = hit_reg;
    assign stat.free_found   = free_found_reg;
    assign stat.victim_found = victim_found_reg;
    assign found_idx         = found_idx_reg;
    assign found_rank        = found_rank_reg;
    assign found_data        = found_data_reg;
    assign found_uses        = found_uses_reg;
    assign free_idx          = free_idx_reg;
    assign victim_idx        = victim_idx_reg;
    assign victim_rank       = victim_rank_reg;

endmodule

// ===== bench/lfu_cache_checker.sv =====
// Checker for the LFU cache: tracks the capacity register, predicts every response and compares.
`timescale 1ns / 100ps

module lfu_cache_checker #(
    parameter int ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  lcl_pkg::req_item_t req_item,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  lcl_pkg::rsp_item_t rsp_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [lcl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 mismatches,
    output int                 awaiting,
    output int                 results_checked
);

    localparam logic [lcl_pkg::ADDR_W-1:0] CAP_ADDR = {lcl_pkg::REG_CAPACITY, 2'b00};

    // Shadow copy of the cache contents and the capacity register.
    logic                       slot_live  [ENTRIES];
    logic [lcl_pkg::KEY_W-1:0]  slot_tag   [ENTRIES];
    logic [lcl_pkg::DATA_W-1:0] slot_value [ENTRIES];
    logic [lcl_pkg::USES_W-1:0] slot_count [ENTRIES];
    int                         slot_age   [ENTRIES];
    int                         fill;
    logic [lcl_pkg::CAP_W-1:0]  capacity_q;

    lcl_pkg::rsp_item_t lookup_answers[$];
    int                 fail_count;
    int                 checked_count;

    function automatic void clear_cache();
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_tag[i]   = '0;
            slot_value[i] = '0;
            slot_count[i] = '0;
            slot_age[i]   = 0;
        end
        fill       = 0;
        capacity_q = lcl_pkg::CAPACITY_RESET;
    endfunction

    function automatic void count_use(input int s);
        if (slot_count[s] != lcl_pkg::USES_MAX)
            slot_count[s] = slot_count[s] + 1'b1;
    endfunction

    // Entries more recent than slot s age by one, and s becomes the newest.
    function automatic void make_newest(input int s);
        int old_age;
        old_age = slot_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != s && slot_age[i] < old_age)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic lcl_pkg::rsp_item_t access_cache(input lcl_pkg::req_item_t it);
        lcl_pkg::rsp_item_t answer;
        int                 eff_cap;
        int                 found;
        int                 slot;
        int                 gone_age;
        eff_cap = (int'(capacity_q) > ENTRIES) ? ENTRIES : int'(capacity_q);
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_live[i] && slot_tag[i] == it.lookup_key)
                found = i;
        answer.hit       = (found >= 0);
        answer.read_data = '0;

        if (it.mode == lcl_pkg::MODE_GET)
        begin
            if (found >= 0)
            begin
                answer.read_data = slot_value[found];
                count_use(found);
                make_newest(found);
            end
            return answer;
        end

        if (eff_cap == 0)
            return answer;

        if (found >= 0)
        begin
            slot_value[found] = it.write_data;
            count_use(found);
            make_newest(found);
            return answer;
        end

        slot = -1;
        if (fill < eff_cap)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !slot_live[i])
                    slot = i;
            fill++;
        end
        else
        begin
            // Victim: lowest use count, oldest among equal counts.
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                    (slot_count[i] == slot_count[slot] && slot_age[i] > slot_age[slot])))
                    slot = i;
            gone_age = slot_age[slot];
            slot_live[slot] = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && slot_age[i] > gone_age)
                    slot_age[i]--;
        end

        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i])
                slot_age[i]++;
        slot_live[slot]  = 1'b1;
        slot_tag[slot]   = it.lookup_key;
        slot_value[slot] = it.write_data;
        slot_count[slot] = 1;
        slot_age[slot]   = 0;
        return answer;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lcl_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            clear_cache();
            lookup_answers.delete();
            fail_count    = 0;
            checked_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
                capacity_q = pwdata[lcl_pkg::CAP_W-1:0];
            if (req_valid && !req_stall)
                lookup_answers.push_back(access_cache(req_item));
            if (rsp_valid && !rsp_stall)
            begin
                if (lookup_answers.size() == 0)
                    report_mismatch($sformatf("response item with no request waiting (hit %b data %h)",
                                              rsp_item.hit, rsp_item.read_data));
                else
                begin
                    want = lookup_answers.pop_front();
                    checked_count++;
                    if (rsp_item.hit !== want.hit)
                        report_mismatch($sformatf("hit is %b, expected %b",
                                                  rsp_item.hit, want.hit));
                    if (rsp_item.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data is %h, expected %h",
                                                  rsp_item.read_data, want.read_data));
                end
            end
        end
        mismatches      <= fail_count;
        awaiting        <= lookup_answers.size();
        results_checked <= checked_count;
    end

endmodule

// ===== bench/lfu_cache_lru_tiebreak_unit_tb.sv =====
// Testbench top for the LFU cache with LRU tie-break: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module lfu_cache_lru_tiebreak_unit_tb;

    localparam int ENTRIES = 64;
    // One item occupies the block for a full scan of the store plus the accept and commit steps.
    localparam int SCAN_CYCLES = ENTRIES + 3;
    // Worst quiet stretch is a scan, a long receiver stall and a long sender gap, all
    // stacked on top of the clearing pass after reset; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [lcl_pkg::ADDR_W-1:0] CAP_ADDR = {lcl_pkg::REG_CAPACITY, 2'b00};

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    lcl_pkg::req_item_t         req_item;
    logic                       rsp_valid;
    logic                       rsp_stall;
    lcl_pkg::rsp_item_t         rsp_item;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lcl_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    int check_fails;
    int awaiting;
    int results_checked;

    // Idling knobs, changed from phase to phase.
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    // Keys are mostly drawn from a small pool so that gets hit and puts overwrite;
    // the first entries of the pool are the extremes of the key range.
    logic [lcl_pkg::KEY_W-1:0] key_pool[128];

    lfu_cache_lru_tiebreak_unit #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lfu_cache_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_item        (req_item),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp_item        (rsp_item),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (check_fails),
        .awaiting        (awaiting),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver alternates between stalled and open runs. Short runs and runs that
    // can outlast a whole scan are mixed so that a stall can catch a result at any point of
    // the block's work, including while the next item is already being scanned.
    initial
    begin : receiver_stalls
        int  run;
        logic stalled;
        run       = 0;
        stalled   = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                stalled = ($urandom_range(99) < stall_pct);
                run = $urandom_range(1) ? $urandom_range(1, 4)
                                        : $urandom_range(1, 2 * SCAN_CYCLES);
            end
            rsp_stall <= stalled;
            run--;
        end
    end

    // The watchdog ends the run when no item has moved on either channel for too long.
    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles, %0d results still due",
                         WATCHDOG_LIMIT, awaiting);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offers one request item and returns once it has been taken. In the idling phases
    // the sender may first drop valid for a random gap, so that the moment it
    // comes back lands anywhere in the block's busy window. Valid otherwise stays high
    // from one item to the next.
    task automatic send_req(input logic m, input logic [lcl_pkg::KEY_W-1:0] k,
                            input logic [lcl_pkg::DATA_W-1:0] d);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 2 * SCAN_CYCLES) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{mode: m, lookup_key: k, write_data: d};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Drains the block: every predicted response must have arrived, then the bench waits
    // a further scan time so that the commit of the last item has surely finished.
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    // APB write: a setup cycle, then an access cycle that completes with pready.
    task automatic write_capacity(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random phase at a fixed capacity and idling mix. The pool size is picked
    // against the capacity so that the cache both hits often and keeps evicting.
    task automatic run_phase(input int cap, input int idle_pct, input int stall,
                             input int count, input int pool_size);
        logic [lcl_pkg::KEY_W-1:0] key;
        wait_idle();
        write_capacity(cap);
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        repeat (count)
        begin
            key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(pool_size - 1)]
                                             : lcl_pkg::KEY_W'($urandom);
            send_req(1'($urandom_range(1)), key, lcl_pkg::DATA_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 128; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity of 64. It starts with a get on the empty
        // cache, stores the extreme keys with extreme values, reads them back, and
        // overwrites a present key with a second put.
        send_req(lcl_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
        send_req(lcl_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(lcl_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(lcl_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_req(lcl_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
        send_req(lcl_pkg::MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_req(lcl_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        send_req(lcl_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_req(lcl_pkg::MODE_GET, 32'h0000_0001, 32'h0000_0000);
        send_req(lcl_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        // Capacity lowered to 2 while four entries are held: new keys now evict one
        // victim each and reuse its slot. The last put meets a tie in use count that
        // must go to the entry accessed longest ago.
        wait_idle();
        write_capacity(2);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0005, 32'hAAAA_5555);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0006, 32'h0F0F_0F0F);
        send_req(lcl_pkg::MODE_GET, 32'h0000_0005, 32'h0000_0000);
        send_req(lcl_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0007, 32'hF0F0_F0F0);
        send_req(lcl_pkg::MODE_GET, 32'h0000_0007, 32'h0000_0000);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0008, 32'h0000_0001);
        send_req(lcl_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);

        // Capacity zero: puts change nothing but still report whether the key is held,
        // and gets keep working.
        wait_idle();
        write_capacity(0);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0009, 32'h0000_0009);
        send_req(lcl_pkg::MODE_PUT, 32'h0000_0007, 32'hDEAD_0000);
        send_req(lcl_pkg::MODE_GET, 32'h0000_0007, 32'h0000_0000);
        send_req(lcl_pkg::MODE_GET, 32'h0000_0009, 32'h0000_0000);

        // Random phases: capacity above the store size, a partly full cache, a single
        // entry, the full store, a capacity lowered below the occupancy, stores
        // disabled, and a small cache with heavy idling on both sides.
        run_phase(127, 0, 0, 100, 96);
        run_phase(8, 78, 0, 90, 16);
        run_phase(1, 0, 78, 60, 4);
        run_phase(64, 34, 34, 110, 80);
        run_phase(5, 0, 0, 70, 10);
        run_phase(0, 34, 34, 20, 80);
        run_phase(3, 78, 78, 50, 8);

        wait_idle();
        $display("Sent %0d request items and checked %0d responses over capacities",
                 items_sent, results_checked);
        $display("0, 1, 2, 3, 5, 8, 64 and 127, with sender gaps and receiver stalls mixed in.");
        if (check_fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lcl_pkg.sv
sv/lcl_ram.sv
sv/lcl_scan_unit.sv
sv/lfu_cache_lru_tiebreak_unit.sv
bench/lfu_cache_checker.sv
bench/lfu_cache_lru_tiebreak_unit_tb.sv
